>>> rtl/vrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_pkg: shared definitions for the voxel ray traversal block
// Field widths and fixed constants used by the interfaces and the modules.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int COORD_W   = 32;  // coordinate and voxel index width
  localparam int SIZE_W    = 25;  // voxel edge length width
  localparam int DIVISOR_W = 32;  // divider divisor and remainder width

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

endpackage
`default_nettype wire

>>> rtl/vrt_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_ifs: channel interfaces of the voxel ray traversal block
// The ray channel carries start and end points; the voxel channel carries
// one visited voxel per transaction.
// ----------------------------------------------------------------------------
interface vrt_ray_if import vrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] start_z;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic signed [COORD_W-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface vrt_vox_if import vrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] voxel_x;
  logic signed [COORD_W-1:0] voxel_y;
  logic signed [COORD_W-1:0] voxel_z;
  logic                      is_end_voxel;
  logic                      truncated;
  logic                      last;

  modport source (output valid, voxel_x, voxel_y, voxel_z, is_end_voxel, truncated, last,
                  input ready);
  modport sink (input valid, voxel_x, voxel_y, voxel_z, is_end_voxel, truncated, last,
                output ready);
endinterface
`default_nettype wire

>>> rtl/vrt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_div: shared restoring divider
// Unsigned long division, one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module vrt_div import vrt_pkg::*; #(
  parameter int DVD_W = 55
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire [DVD_W-1:0]      dividend,
  input  wire [DIVISOR_W-1:0]  divisor,
  output logic                 done,
  output logic [DVD_W-1:0]     quotient,
  output logic [DIVISOR_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DVD_W-1:0]     dvd;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;

  logic [DIVISOR_W:0]   trial;
  logic                 ge;
  logic [DIVISOR_W:0]   diff;

  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        dvd <= {dvd[DVD_W-2:0], ge};
        rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule
`default_nettype wire

>>> rtl/voxel_ray_traversal_3d_top.sv
`default_nettype none
// Operation: set-up runs twelve divisions on one shared divider, then the walk
//   emits one voxel per cycle while the output is taken, up to MAX_VOXELS results.
// Throughput: one ray at a time; the next ray is accepted once the end voxel
//   has been loaded into the output register.
// Reset: synchronous, active high; the voxel edge length returns to 256.
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d_top: 3D DDA voxel ray traversal
// Walks the voxels crossed by a ray from start to end and emits each index,
// followed by the end voxel flagged as last.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_3d_top import vrt_pkg::*; #(
  parameter int MAX_VOXELS  = 64,
  parameter int T_FRAC_BITS = 30
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_wr_en,
  input  wire [SIZE_W-1:0] cfg_wr_data,
  vrt_ray_if.sink          ray,
  vrt_vox_if.source        vox
);

  // Crossing parameters are unsigned with two integer bits. The all-ones code
  // stands for infinity and is what an axis of zero length carries.
  localparam int TW    = T_FRAC_BITS + 2;
  localparam int DW    = SIZE_W + T_FRAC_BITS;
  localparam int CNT_W = $clog2(MAX_VOXELS);
  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0] T_SAT = '1;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_WALK} state_t;
  // The four divisions run per axis, in this order.
  typedef enum logic [1:0] {K_FLOOR_S, K_FLOOR_E, K_TDEL, K_TMAX} op_t;

  state_t state;
  op_t    kind;
  logic [1:0] axis;

  logic [SIZE_W-1:0]         size_r;
  logic signed [COORD_W-1:0] s    [3];
  logic signed [COORD_W-1:0] e    [3];
  logic signed [COORD_W-1:0] cur  [3];
  logic signed [COORD_W-1:0] endc [3];
  logic [SIZE_W-1:0]         num  [3];
  logic [TW-1:0]             tdel [3];
  logic [TW-1:0]             tmax [3];
  logic [2:0]                dpos;
  logic                      sat_r;
  logic [CNT_W-1:0]          cnt;

  logic                      ov_valid;
  logic signed [COORD_W-1:0] ov_x, ov_y, ov_z;
  logic                      ov_end, ov_trunc, ov_last;

  // The voxel size register. A written zero behaves as a size of one.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_r <= (cfg_wr_data == '0) ? SIZE_W'(1) : cfg_wr_data;
    end
  end

  // Operand selection for the divider, worked out from the current axis.
  logic signed [COORD_W-1:0] sa, ea;
  logic signed [COORD_W:0]   dif;
  logic [COORD_W:0]          dif_abs;
  logic [DIVISOR_W-1:0]      ad;
  logic [COORD_W-1:0]        abs_s, abs_e;
  logic [SIZE_W-1:0]         num_sel;
  logic                      sat;
  logic [DW-1:0]             div_dvd;
  logic [DIVISOR_W-1:0]      div_dvs;
  logic                      div_start, div_done;
  logic [DW-1:0]             div_q;
  logic [DIVISOR_W-1:0]      div_r;

  assign sa      = s[axis];
  assign ea      = e[axis];
  assign dif     = {ea[COORD_W-1], ea} - {sa[COORD_W-1], sa};
  assign dif_abs = dif[COORD_W] ? ((COORD_W+1)'(0) - dif) : dif;
  assign ad      = dif_abs[DIVISOR_W-1:0];
  assign abs_s   = sa[COORD_W-1] ? (COORD_W'(0) - sa) : sa;
  assign abs_e   = ea[COORD_W-1] ? (COORD_W'(0) - ea) : ea;
  assign num_sel = (kind == K_TDEL) ? size_r : num[axis];
  // The quotient would need more than two integer bits: clamp to infinity.
  assign sat     = (dif == '0) || ({10'b0, num_sel} >= {1'b0, ad, 2'b00});

  always_comb begin
    case (kind)
      K_FLOOR_S: begin
        div_dvd = DW'(abs_s);
        div_dvs = DIVISOR_W'(size_r);
      end
      K_FLOOR_E: begin
        div_dvd = DW'(abs_e);
        div_dvs = DIVISOR_W'(size_r);
      end
      default: begin
        div_dvd = {num_sel, {T_FRAC_BITS{1'b0}}};
        div_dvs = ad;
      end
    endcase
  end

  assign div_start = (state == S_ISSUE);

  vrt_div #(
    .DVD_W(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  // Floor division from the magnitude quotient: a negative operand with a
  // remainder rounds one further down, and its floor remainder is mirrored.
  logic                      fneg, rnz;
  logic [COORD_W-1:0]        q32;
  logic signed [COORD_W-1:0] fl;
  logic [SIZE_W-1:0]         rf;

  assign fneg = (kind == K_FLOOR_S) ? sa[COORD_W-1] : ea[COORD_W-1];
  assign q32  = div_q[COORD_W-1:0];
  assign rnz  = (div_r != '0);
  assign fl   = fneg ? (COORD_W'(0) - (q32 + COORD_W'(rnz))) : q32;
  assign rf   = (fneg && rnz) ? (size_r - div_r[SIZE_W-1:0]) : div_r[SIZE_W-1:0];

  // One step of the walk: the axis with the smallest crossing parameter
  // moves, ties going to the later axis.
  logic [1:0]                m;
  logic [TW-1:0]             tm;
  logic [TW:0]               tsum;
  logic [TW-1:0]             tnew;
  logic signed [COORD_W:0]   cur_new;
  logic signed [COORD_W:0]   endc_m;
  logic                      over, past_one, at_end, can_emit, cnt_full, emit;

  assign m = (tmax[0] < tmax[1] && tmax[0] < tmax[2]) ? 2'd0 :
             ((tmax[1] < tmax[2]) ? 2'd1 : 2'd2);
  assign tm       = tmax[m];
  assign past_one = tm > T_ONE;
  assign tsum     = {1'b0, tm} + {1'b0, tdel[m]};
  assign tnew     = tsum[TW] ? T_SAT : tsum[TW-1:0];
  assign cur_new  = {cur[m][COORD_W-1], cur[m]} + (dpos[m] ? (COORD_W+1)'(1) : '1);
  assign endc_m   = {endc[m][COORD_W-1], endc[m]};
  assign over     = dpos[m] ? (cur_new > endc_m) : (cur_new < endc_m);
  assign at_end   = (cur[0] == endc[0]) && (cur[1] == endc[1]) && (cur[2] == endc[2]);
  assign can_emit = !ov_valid || vox.ready;
  assign cnt_full = (cnt == CNT_W'(MAX_VOXELS-1));
  // A result is loaded into the output register in this cycle.
  assign emit     = (state == S_WALK) && can_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ov_valid <= 1'b0;
    end else begin
      if (emit) begin
        ov_valid <= 1'b1;
      end else if (vox.ready) begin
        ov_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ray.valid) begin
            s[0]  <= ray.start_x;
            s[1]  <= ray.start_y;
            s[2]  <= ray.start_z;
            e[0]  <= ray.end_x;
            e[1]  <= ray.end_y;
            e[2]  <= ray.end_z;
            axis  <= 2'd0;
            kind  <= K_FLOOR_S;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          sat_r <= sat;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            case (kind)
              K_FLOOR_S: begin
                cur[axis]  <= fl;
                dpos[axis] <= !dif[COORD_W] && (dif != '0);
                num[axis]  <= (!dif[COORD_W] && (dif != '0)) ? (size_r - rf) : rf;
              end
              K_FLOOR_E: endc[axis] <= fl;
              K_TDEL:    tdel[axis] <= sat_r ? T_SAT : div_q[TW-1:0];
              default:   tmax[axis] <= sat_r ? T_SAT : div_q[TW-1:0];
            endcase
            if (kind == K_TMAX) begin
              kind <= K_FLOOR_S;
              if (axis == 2'd2) begin
                cnt   <= '0;
                state <= S_WALK;
              end else begin
                axis  <= axis + 2'd1;
                state <= S_ISSUE;
              end
            end else begin
              kind  <= op_t'(kind + 2'd1);
              state <= S_ISSUE;
            end
          end
        end
        S_WALK: begin
          if (can_emit) begin
            if (at_end || cnt_full) begin
              // Final transaction: the end voxel, flagged as last.
              ov_x     <= endc[0];
              ov_y     <= endc[1];
              ov_z     <= endc[2];
              ov_end   <= 1'b1;
              ov_trunc <= !at_end;
              ov_last  <= 1'b1;
              state    <= S_IDLE;
            end else begin
              ov_x     <= cur[0];
              ov_y     <= cur[1];
              ov_z     <= cur[2];
              ov_end   <= 1'b0;
              ov_trunc <= 1'b0;
              ov_last  <= 1'b0;
              cnt      <= cnt + 1'b1;
              if (past_one || over) begin
                // Past the segment end, or beyond the end voxel: jump there.
                cur[0] <= endc[0];
                cur[1] <= endc[1];
                cur[2] <= endc[2];
              end else begin
                cur[m] <= cur_new[COORD_W-1:0];
              end
              if (!past_one) begin
                tmax[m] <= tnew;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ray.ready        = (state == S_IDLE);
  assign vox.valid        = ov_valid;
  assign vox.voxel_x      = ov_x;
  assign vox.voxel_y      = ov_y;
  assign vox.voxel_z      = ov_z;
  assign vox.is_end_voxel = ov_end;
  assign vox.truncated    = ov_trunc;
  assign vox.last         = ov_last;

  // The final transaction always carries the end voxel flag.
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    vox.valid && vox.last |-> vox.is_end_voxel)
    else $error("last result without end voxel flag");

  // A truncated walk is only ever reported on the final transaction.
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    vox.valid && vox.truncated |-> vox.last)
    else $error("truncated flag on a non-final result");

  // The divider is only started while no division is outstanding.
  a_div_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |=> (state == S_WAIT))
    else $error("division issued twice");

  // While the output is stalled the walk position holds.
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) && !can_emit |=> $stable(cnt))
    else $error("walk advanced under a stalled output");

endmodule
`default_nettype wire
